@@ design/c2p_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// constants and types for the cartesian to polar converter
// arctangent table in fractions of a full turn, gain constant, guard bits
// no dependencies
package c2p_pkg;

  typedef logic [31:0] turn_t;

  localparam int GUARD = 16;
  localparam int OUT_W = 16;
  localparam int MAX_STEPS = 32;
  localparam logic [31:0] GAIN_Q32 = 32'h9B74EDA8;
  localparam turn_t HALF_TURN = 32'h80000000;

  localparam turn_t ATAN_TURNS [MAX_STEPS] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
    32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
    32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
    32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
  };

endpackage
`default_nettype wire

@@ design/cartesian_to_polar_top.sv @@
`timescale 1ns / 1ps
`default_nettype none
// throughput: one word per cycle while out_tready is high, set by one register stage per cordic micro-rotation
// and three stages for the split gain multiply and rounding
// each stage holds its word while the next one cannot take it, so bubbles are squeezed out
// reset: synchronous active-low rst_n clears all valid bits, the pipeline empties
// depends on c2p_pkg
module cartesian_to_polar_top #(
  parameter int DATA_WIDTH  = 16,
  parameter int ANGLE_WIDTH = 16,
  parameter int ITERATIONS  = 16
) (
  input  wire                                   clk,
  input  wire                                   rst_n,
  input  wire                                   in_tvalid,
  output logic                                  in_tready,
  // x_offset, y_offset
  input  wire  [((2*DATA_WIDTH+7)/8)*8-1:0]     in_tdata,
  output logic                                  out_tvalid,
  input  wire                                   out_tready,
  // magnitude, angle_turns
  output logic [31:0]                           out_tdata
);
  import c2p_pkg::*;

  localparam int W = DATA_WIDTH + GUARD + 3;
  localparam int LAST = ITERATIONS;
  localparam int SH = 32 - ANGLE_WIDTH;
  localparam logic [31:0] ANG_RND = 32'((64'd1 << SH) >> 1);

  // cordic stages: 0 is the pre-rotation, k holds the word after step k-1
  logic [LAST:0]         cv_r;
  logic [LAST:0]         crdy;
  logic [LAST:0]         zero_r;
  logic signed [W-1:0]   x_r [0:LAST];
  logic signed [W-1:0]   y_r [0:LAST];
  turn_t                 z_r [0:LAST];

  logic                  m1_v_r, m1_zero_r, m1_rdy;
  logic [63:0]           m1_plo_r;
  logic [31:0]           m1_hi_r;
  logic [OUT_W-1:0]      m1_ang_r;

  logic                  m2_v_r, m2_zero_r, m2_rdy;
  logic [63:0]           m2_t_r;
  logic [OUT_W-1:0]      m2_ang_r;

  logic                  out_v_r, out_rdy;
  logic [OUT_W-1:0]      out_mag_r, out_ang_r;

  logic [DATA_WIDTH-1:0] in_x, in_y;
  logic signed [W-1:0]   x_ext, y_ext;
  logic                  in_zero;
  logic [63:0]           xf;
  turn_t                 z_rnd;
  logic [31:0]           ang32;
  logic [63:0]           m2_phi;
  logic [64:0]           mag_rnd;
  logic [48:0]           mag_q;

  // ready chain
  assign out_rdy = !out_v_r || out_tready;
  assign m2_rdy  = !m2_v_r || out_rdy;
  assign m1_rdy  = !m1_v_r || m2_rdy;
  assign crdy[LAST] = !cv_r[LAST] || m1_rdy;
  genvar k;
  generate
    for (k = 0; k < LAST; k++) begin : g_rdy
      assign crdy[k] = !cv_r[k] || crdy[k+1];
    end
  endgenerate
  assign in_tready = crdy[0];

  // pre-rotation by a half turn for negative x
  assign in_x    = in_tdata[DATA_WIDTH-1:0];
  assign in_y    = in_tdata[2*DATA_WIDTH-1:DATA_WIDTH];
  assign x_ext   = {{(W-DATA_WIDTH){in_x[DATA_WIDTH-1]}}, in_x};
  assign y_ext   = {{(W-DATA_WIDTH){in_y[DATA_WIDTH-1]}}, in_y};
  assign in_zero = (in_x == '0) && (in_y == '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cv_r[0] <= 1'b0;
    end else if (crdy[0]) begin
      cv_r[0] <= in_tvalid;
    end
    if (crdy[0]) begin
      zero_r[0] <= in_zero;
      if (in_x[DATA_WIDTH-1]) begin
        x_r[0] <= (-x_ext) <<< GUARD;
        y_r[0] <= (-y_ext) <<< GUARD;
        z_r[0] <= HALF_TURN;
      end else begin
        x_r[0] <= x_ext <<< GUARD;
        y_r[0] <= y_ext <<< GUARD;
        z_r[0] <= '0;
      end
    end
  end

  // one micro-rotation per stage
  generate
    for (k = 1; k <= LAST; k++) begin : g_step
      always_ff @(posedge clk) begin
        if (!rst_n) begin
          cv_r[k] <= 1'b0;
        end else if (crdy[k]) begin
          cv_r[k] <= cv_r[k-1];
        end
        if (crdy[k]) begin
          zero_r[k] <= zero_r[k-1];
          if (!y_r[k-1][W-1]) begin
            x_r[k] <= x_r[k-1] + (y_r[k-1] >>> (k-1));
            y_r[k] <= y_r[k-1] - (x_r[k-1] >>> (k-1));
            z_r[k] <= z_r[k-1] + ATAN_TURNS[k-1];
          end else begin
            x_r[k] <= x_r[k-1] - (y_r[k-1] >>> (k-1));
            y_r[k] <= y_r[k-1] + (x_r[k-1] >>> (k-1));
            z_r[k] <= z_r[k-1] - ATAN_TURNS[k-1];
          end
        end
      end
    end
  endgenerate

  // gain multiply, low half, and angle rounding
  assign xf    = x_r[LAST][W-1] ? 64'd0 : {{(64-W){1'b0}}, x_r[LAST]};
  assign z_rnd = z_r[LAST] + ANG_RND;
  assign ang32 = z_rnd >> SH;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m1_v_r <= 1'b0;
    end else if (m1_rdy) begin
      m1_v_r <= cv_r[LAST];
    end
    if (m1_rdy) begin
      m1_plo_r  <= 64'(xf[31:0]) * 64'(GAIN_Q32);
      m1_hi_r   <= xf[63:32];
      m1_ang_r  <= ang32[OUT_W-1:0];
      m1_zero_r <= zero_r[LAST];
    end
  end

  // gain multiply, high half
  assign m2_phi = 64'(m1_hi_r) * 64'(GAIN_Q32);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m2_v_r <= 1'b0;
    end else if (m2_rdy) begin
      m2_v_r <= m1_v_r;
    end
    if (m2_rdy) begin
      m2_t_r    <= m2_phi + (m1_plo_r >> 32);
      m2_ang_r  <= m1_ang_r;
      m2_zero_r <= m1_zero_r;
    end
  end

  // round away guard bits and saturate
  assign mag_rnd = {1'b0, m2_t_r} + 65'(1 << (GUARD - 1));
  assign mag_q   = mag_rnd[64:GUARD];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (out_rdy) begin
      out_v_r <= m2_v_r;
    end
    if (out_rdy) begin
      if (m2_zero_r) begin
        out_mag_r <= '0;
        out_ang_r <= '0;
      end else begin
        out_mag_r <= (|mag_q[48:OUT_W]) ? {OUT_W{1'b1}} : mag_q[OUT_W-1:0];
        out_ang_r <= m2_ang_r;
      end
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {out_ang_r, out_mag_r};

endmodule
`default_nettype wire

@@ verif/tb_cartesian_to_polar_top.sv @@
`timescale 1ns / 1ps
// testbench for cartesian_to_polar_top: streams (x, y) words in, checks magnitude and angle
// against a bit-exact cordic vectoring model kept in a small scoreboard class
// depends on design/c2p_pkg.sv and design/cartesian_to_polar_top.sv
module tb_cartesian_to_polar_top;

  localparam int STEPS = 16;
  localparam int FRAC_BITS = 16;
  localparam int TAIL_CYCLES = STEPS + 4 + 20;
  localparam logic [31:0] CORDIC_GAIN = 32'h9B74EDA8;
  localparam logic [31:0] HALF_CIRCLE = 32'h80000000;
  localparam logic [31:0] ARCTAN_STEP [32] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
    32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
    32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
    32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
  };
  localparam int ITEMS_PER_PHASE = 520;

  typedef struct packed {
    logic [15:0] angle_turns;
    logic [15:0] magnitude;
  } polar_t;

  class polar_scoreboard;
    polar_t polar_due[$];
    int errors = 0;

    function automatic polar_t cordic_polar(logic signed [15:0] xo, logic signed [15:0] yo);
      longint x;
      longint y;
      longint dx;
      longint dy;
      logic [31:0] z;
      logic [63:0] xf;
      logic [63:0] scaled;
      logic [63:0] mag;
      logic [63:0] ang;
      polar_t r;
      x = xo;
      y = yo;
      z = '0;
      if (x == 0 && y == 0) begin
        return '0;
      end
      if (x < 0) begin
        x = -x;
        y = -y;
        z = HALF_CIRCLE;
      end
      x = x * (64'sd1 <<< FRAC_BITS);
      y = y * (64'sd1 <<< FRAC_BITS);
      for (int i = 0; i < STEPS; i++) begin
        dx = y >>> i;
        dy = x >>> i;
        if (y >= 0) begin
          x = x + dx;
          y = y - dy;
          z = z + ARCTAN_STEP[i];
        end else begin
          x = x - dx;
          y = y + dy;
          z = z - ARCTAN_STEP[i];
        end
      end
      xf = (x < 0) ? 64'd0 : 64'(x);
      scaled = 64'(xf[63:32]) * 64'(CORDIC_GAIN)
             + ((64'(xf[31:0]) * 64'(CORDIC_GAIN)) >> 32);
      mag = (scaled + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
      r.magnitude = (mag > 64'hFFFF) ? 16'hFFFF : mag[15:0];
      ang = (64'(z) + 64'h8000) >> 16;
      r.angle_turns = ang[15:0];
      return r;
    endfunction

    function void add_coordinate(logic [15:0] xo, logic [15:0] yo);
      polar_due.push_back(cordic_polar(xo, yo));
    endfunction

    function void check_polar(logic [31:0] word);
      polar_t got;
      polar_t want;
      got = word;
      if (polar_due.size() == 0) begin
        $display("%0t: unexpected word, expected none, actual mag %0d angle %0d",
                 $time, got.magnitude, got.angle_turns);
        errors++;
        return;
      end
      want = polar_due.pop_front();
      if (got.magnitude !== want.magnitude) begin
        $display("%0t: magnitude expected %0d actual %0d", $time, want.magnitude,
                 got.magnitude);
        errors++;
      end
      if (got.angle_turns !== want.angle_turns) begin
        $display("%0t: angle_turns expected %0d actual %0d", $time, want.angle_turns,
                 got.angle_turns);
        errors++;
      end
    endfunction

    function int pending();
      return polar_due.size();
    endfunction
  endclass

  logic clk;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  // x_offset, y_offset
  logic [31:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  // magnitude, angle_turns
  logic [31:0] out_tdata;

  int send_idle_pct = 13;
  int recv_stall_pct = 53;
  polar_scoreboard polar_sb = new();

  cartesian_to_polar_top uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      polar_sb.check_polar(out_tdata);
    end
    out_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  task automatic send_word(input logic [15:0] xo, input logic [15:0] yo);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {yo, xo};
    do @(posedge clk); while (!in_tready);
    polar_sb.add_coordinate(xo, yo);
  endtask

  function automatic logic [15:0] pick_offset();
    logic [15:0] v;
    case ($urandom_range(9))
      0, 1, 2, 3, 4, 5: v = 16'($urandom());
      6, 7: v = 16'($urandom_range(64)) - 16'd32;
      8: v = 16'($urandom_range(4)) - 16'd2;
      default: begin
        case ($urandom_range(5))
          0: v = 16'h8000;
          1: v = 16'h8001;
          2: v = 16'hFFFF;
          3: v = 16'h0000;
          4: v = 16'h0001;
          default: v = 16'h7FFF;
        endcase
      end
    endcase
    return v;
  endfunction

  task automatic send_random(input int count);
    for (int n = 0; n < count; n++) begin
      send_word(pick_offset(), pick_offset());
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // axes, corners, negative x half turn, angle wrapping to zero
    send_word(16'h0000, 16'h0000);
    send_word(16'h7FFF, 16'h0000);
    send_word(16'h8000, 16'h0000);
    send_word(16'h0000, 16'h7FFF);
    send_word(16'h0000, 16'h8000);
    send_word(16'h7FFF, 16'h7FFF);
    send_word(16'h8000, 16'h8000);
    send_word(16'h8000, 16'h7FFF);
    send_word(16'h7FFF, 16'h8000);
    send_word(16'h0001, 16'h0000);
    send_word(16'hFFFF, 16'h0000);
    send_word(16'h0000, 16'h0001);
    send_word(16'h0000, 16'hFFFF);
    send_word(16'hFFFF, 16'hFFFF);
    send_word(16'h0001, 16'h0001);
    send_word(16'h7FFF, 16'hFFFF);
    send_word(16'h4E20, 16'hFFFF);
    send_word(16'hFFFF, 16'h0001);
    send_word(16'h8000, 16'hFFFF);
    send_word(16'h5555, 16'hAAAA);
    send_word(16'hAAAA, 16'h5555);

    send_random(ITEMS_PER_PHASE);
    send_idle_pct = 53;
    recv_stall_pct = 13;
    send_random(ITEMS_PER_PHASE);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    send_random(ITEMS_PER_PHASE);
    in_tvalid <= 1'b0;

    while (polar_sb.pending() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (polar_sb.errors == 0) begin
      $display("cartesian_to_polar_top: match");
    end else begin
      $display("cartesian_to_polar_top: mismatch");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("%0t: timeout, %0d words still expected", $time, polar_sb.pending());
    $display("cartesian_to_polar_top: mismatch");
    $finish;
  end

endmodule

@@ files.f @@
design/c2p_pkg.sv
design/cartesian_to_polar_top.sv
verif/tb_cartesian_to_polar_top.sv
